// ----- rtl/core/iqs_pkg.sv -----
// Package for the in-place quicksort block: shared constants and types.
package iqs_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int PORT_WIDTH     = 32;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_POP,
    ST_POPWAIT,
    ST_RANGE,
    ST_RDPIV,
    ST_RDL,
    ST_RDR,
    ST_CMP,
    ST_WR2,
    ST_WR3,
    ST_PUSH,
    ST_OUTRD,
    ST_OUT
  } iqs_state_t;

  // Datapath command from controller
  typedef struct packed {
    logic load;       // write input element, bump count
    logic clr_count;  // end of run
    logic init;       // seed stack with whole set
    logic pop;        // read stack top
    logic take_range; // latch popped range into cursors
    logic rd_piv;     // read pivot element
    logic rd_left;    // read left element
    logic rd_right;   // read right element
    logic step;       // compare and do first write of step
    logic wr2;        // second write of swap/rotate
    logic wr3;        // third write of rotate
    logic push;       // push subranges
    logic out_start;  // clear output index
    logic out_rd;     // read output element
    logic out_emit;   // present result
  } iqs_cmd_t;

  // Datapath status to controller
  typedef struct packed {
    logic set_done;    // current item closes the set
    logic multi;       // set has at least two elements
    logic stack_empty;
    logic range_ok;    // popped range is valid
    logic part_run;    // left <= right
    logic need_wr2;
    logic need_wr3;
    logic out_last;
  } iqs_stat_t;

endpackage

// ----- rtl/core/in_place_quicksort.sv -----
// Top level of the in-place quicksort block.
// A set of 1..DEPTH values is loaded one per cycle while busy is low; last
// (or the DEPTH-th value) closes it. The block then sorts in place through
// the element store, partitioning each range popped from the range stack
// and pushing its subranges back. It then emits the values in ascending
// signed order, each marked by done for one cycle, with done low between
// them; final_res marks the last. The receiver cannot stall; busy rises once
// the closing item is taken and stays high until the last result is on the
// ports, and is low again in that cycle.
module in_place_quicksort #(
  parameter int DEPTH      = iqs_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = iqs_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [iqs_pkg::PORT_WIDTH-1:0] value,
  input  logic                           last,
  output logic                           done,
  output logic [iqs_pkg::PORT_WIDTH-1:0] sorted_value,
  output logic                           final_res
);
  import iqs_pkg::*;

  iqs_cmd_t  cmd;
  iqs_stat_t stat;

  iqs_ctrl u_ctrl (
    .clk, .rst, .start, .busy, .stat, .cmd
  );

  iqs_datapath #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk, .rst, .cmd, .stat, .value, .last,
    .sorted_value, .final_res, .result_valid(done)
  );
endmodule

// ----- rtl/core/iqs_ram.sv -----
// Generic single-port write, one-port read RAM with registered read data.
module iqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/core/iqs_datapath.sv -----
// Datapath: element store, range stack, partition cursors and output.
module iqs_datapath #(
  parameter int DEPTH      = iqs_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = iqs_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  iqs_pkg::iqs_cmd_t                  cmd,
  output iqs_pkg::iqs_stat_t                 stat,
  input  logic [iqs_pkg::PORT_WIDTH-1:0]     value,
  input  logic                               last,
  output logic [iqs_pkg::PORT_WIDTH-1:0]     sorted_value,
  output logic                               final_res,
  output logic                               result_valid
);
  import iqs_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;

  // Cursors and counters
  logic [CW-1:0] count;
  logic [CW-1:0] sp;
  logic [AW-1:0] piv, lo, hi;
  logic [CW-1:0] lft, rgt;
  logic [AW-1:0] oidx;
  logic [DATA_WIDTH-1:0] pv, lv, rv;
  logic          is_less_l, is_less_r;

  // Element store ports
  logic                  e_we;
  logic [AW-1:0]         e_waddr, e_raddr;
  logic [DATA_WIDTH-1:0] e_wdata, e_rdata;

  // Stack ports
  logic            s_we;
  logic [AW-1:0]   s_waddr, s_raddr;
  logic [2*AW-1:0] s_wdata, s_rdata;

  // Push bookkeeping: right part first, then left part
  logic          push_r_ok, push_l_ok;
  logic          push_phase;

  iqs_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_elem (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rdata)
  );
  iqs_ram #(.WIDTH(2*AW), .DEPTH(DEPTH)) u_stack (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata)
  );

  // Compare on stored elements: lv is the left element, e_rdata the right one
  assign is_less_l = $signed(lv) < $signed(pv);
  assign is_less_r = $signed(e_rdata) < $signed(pv);

  // Subrange validity
  assign push_r_ok = ({1'b0, piv} + CW'(1)) < {1'b0, hi};
  assign push_l_ok = (piv > lo) && ((piv - AW'(1)) > lo);

  // Read address select
  always_comb begin
    e_raddr = piv;
    if (cmd.rd_left)  e_raddr = lft[AW-1:0];
    if (cmd.rd_right) e_raddr = rgt[AW-1:0];
    if (cmd.out_rd)   e_raddr = oidx;
  end
  // sp already points at the popped entry in the cycle after the pop
  assign s_raddr = sp[AW-1:0];

  // Write port select for load and the swap/rotate steps
  always_comb begin
    e_we    = 1'b0;
    e_waddr = count[AW-1:0];
    e_wdata = DATA_WIDTH'($signed(value));
    if (cmd.load) begin
      e_we = 1'b1;
    end else if (cmd.step) begin
      // e_rdata holds right element here, lv the left one
      if (is_less_l) begin
        e_we = 1'b1; e_waddr = piv; e_wdata = lv;
      end else if (is_less_r) begin
        e_we = 1'b1; e_waddr = piv; e_wdata = e_rdata;
      end
    end else if (cmd.wr2) begin
      e_we = 1'b1;
      if (stat.need_wr3) begin
        e_waddr = rgt[AW-1:0]; e_wdata = lv;
      end else begin
        e_waddr = lft[AW-1:0]; e_wdata = pv;
      end
    end else if (cmd.wr3) begin
      e_we = 1'b1; e_waddr = lft[AW-1:0]; e_wdata = pv;
    end
  end

  // Stack writes
  always_comb begin
    s_we    = 1'b0;
    s_waddr = sp[AW-1:0];
    s_wdata = {lo, hi};
    if (cmd.init) begin
      s_we = count >= CW'(2); s_waddr = '0; s_wdata = {AW'(0), AW'(count - CW'(1))};
    end else if (cmd.push) begin
      if (!push_phase && push_r_ok) begin
        s_we = 1'b1; s_wdata = {piv + AW'(1), hi};
      end else if (push_phase && push_l_ok) begin
        s_we = 1'b1; s_wdata = {lo, piv - AW'(1)};
      end
    end
  end

  logic rot_flag, swp_flag;

  // Sequential datapath state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0; sp <= '0; push_phase <= 1'b0; rot_flag <= 1'b0; swp_flag <= 1'b0;
      piv <= '0; lft <= '0; rgt <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.out_emit;
      if (cmd.load) count <= count + CW'(1);
      if (cmd.clr_count) count <= '0;
      if (cmd.init) sp <= (count >= CW'(2)) ? CW'(1) : '0;
      if (cmd.pop) sp <= sp - CW'(1);
      if (cmd.push) begin
        if (s_we) sp <= sp + CW'(1);
        push_phase <= ~push_phase;
      end
      // Cursors from the popped range
      if (cmd.take_range) begin
        piv <= s_rdata[2*AW-1:AW];
        lft <= {1'b0, s_rdata[2*AW-1:AW]} + CW'(1);
        rgt <= {1'b0, s_rdata[AW-1:0]};
      end
      if (cmd.step) begin
        swp_flag <= is_less_l;
        rot_flag <= !is_less_l && is_less_r;
      end
      if (cmd.wr2) begin
        swp_flag <= 1'b0;
        if (!rot_flag) begin
          piv <= lft[AW-1:0]; lft <= lft + CW'(1);
        end
      end
      if (cmd.wr3) begin
        rot_flag <= 1'b0;
        piv <= lft[AW-1:0]; lft <= lft + CW'(1); rgt <= rgt - CW'(1);
      end
      if (cmd.step && !is_less_l && !is_less_r) rgt <= rgt - CW'(1);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.take_range) begin
      lo  <= s_rdata[2*AW-1:AW];
      hi  <= s_rdata[AW-1:0];
    end
    if (cmd.rd_left)  pv <= e_rdata;
    if (cmd.rd_right) lv <= e_rdata;
    if (cmd.step)     rv <= e_rdata;
    if (cmd.out_start) oidx <= '0;
    if (cmd.out_emit) begin
      sorted_value <= PORT_WIDTH'($signed(e_rdata));
      final_res    <= ({1'b0, oidx} + CW'(1)) == count;
      oidx         <= oidx + AW'(1);
    end
  end

  // Status to controller
  always_comb begin
    stat.set_done    = last || (count == CW'(DEPTH - 1));
    stat.multi       = count >= CW'(2);
    stat.stack_empty = sp == '0;
    stat.range_ok    = (s_rdata[AW-1:0] > s_rdata[2*AW-1:AW]) &&
                       ({1'b0, s_rdata[AW-1:0]} < count);
    stat.part_run    = lft <= rgt;
    stat.need_wr2    = swp_flag || rot_flag;
    stat.need_wr3    = rot_flag;
    stat.out_last    = ({1'b0, oidx} + CW'(1)) == count;
  end
endmodule

// ----- rtl/core/iqs_ctrl.sv -----
// Controller state machine for load, partition passes and output.
module iqs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  iqs_pkg::iqs_stat_t stat,
  output iqs_pkg::iqs_cmd_t  cmd
);
  import iqs_pkg::*;

  iqs_state_t state, state_next;
  logic       push_two;

  // The push state's right-part and left-part pushes are tracked here
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD; push_two <= 1'b0;
    end else begin
      state <= state_next;
      push_two <= (state == ST_PUSH) ? ~push_two : 1'b0;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:    if (start && stat.set_done) state_next = ST_INIT;
      ST_INIT:    state_next = ST_POP;
      ST_POP:     state_next = stat.stack_empty ? ST_OUTRD : ST_POPWAIT;
      ST_POPWAIT: state_next = ST_RANGE;
      ST_RANGE:   state_next = stat.range_ok ? ST_RDPIV : ST_POP;
      ST_RDPIV:   state_next = stat.part_run ? ST_RDL : ST_PUSH;
      ST_RDL:     state_next = ST_RDR;
      ST_RDR:     state_next = ST_CMP;
      ST_CMP:     state_next = ST_WR2;
      ST_WR2:     state_next = stat.need_wr3 ? ST_WR3 : ST_RDPIV;
      ST_WR3:     state_next = ST_RDPIV;
      ST_PUSH:    if (push_two) state_next = ST_POP;
      ST_OUTRD:   state_next = ST_OUT;
      ST_OUT:     state_next = stat.out_last ? ST_LOAD : ST_OUTRD;
      default:    state_next = ST_LOAD;
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_LOAD: begin
        busy = 1'b0;
        cmd.load = start;
      end
      ST_INIT: begin
        cmd.init      = 1'b1;
        cmd.out_start = 1'b1;
      end
      ST_POP:     cmd.pop = !stat.stack_empty;
      ST_POPWAIT: ;
      ST_RANGE:   cmd.take_range = stat.range_ok;
      ST_RDPIV:   ;
      ST_RDL:     cmd.rd_left = 1'b1;
      ST_RDR:     cmd.rd_right = 1'b1;
      ST_CMP:     cmd.step = 1'b1;
      ST_WR2:     cmd.wr2 = stat.need_wr2;
      ST_WR3:     cmd.wr3 = 1'b1;
      ST_PUSH:    cmd.push = 1'b1;
      ST_OUTRD: begin
        cmd.out_rd = 1'b1;
      end
      ST_OUT: begin
        cmd.out_rd    = 1'b1;
        cmd.out_emit  = 1'b1;
        cmd.clr_count = stat.out_last;
      end
      default: ;
    endcase
  end
endmodule

// ----- rtl/core/iqs_checker.sv -----
// Port-level checker for the in-place quicksort block, bound to the top level.
module iqs_checker (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        done,
  input logic        final_res,
  input logic [31:0] sorted_value
);
  // A result is only flagged if busy was high just before it
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result outside a run");
  // A result carries known payload
  a_known: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown({sorted_value, final_res})) else $error("unknown result payload");
  // After the last result the block is ready again
  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    done && final_res |-> !busy) else $error("busy after final result");
  // A result is never followed directly by another
  a_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("back-to-back results");
endmodule

bind in_place_quicksort iqs_checker u_iqs_checker (
  .clk, .rst, .busy, .done, .final_res, .sorted_value
);
